@@ sv/sau_pkg.sv @@
// Shared definitions for the stack arithmetic unit: data width, default
// stack depth and the operation and status codes.
// No dependencies.
package sau_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_W       = 7;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int STACK_DEPTH_D = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_NOP  = 3'd0,
    FUNC_ADD  = 3'd1,
    FUNC_SUB  = 3'd2,
    FUNC_DIV  = 3'd3,
    FUNC_MUL  = 3'd4,
    FUNC_PUSH = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_DIVZERO = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

endpackage

@@ sv/sau_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/stack_arithmetic_unit_top.sv @@
// Top level of the stack arithmetic unit.
// Depends on sau_pkg and sau_ram.

// The unit keeps a last-in first-out stack of signed 32-bit entries and runs
// one operation per input transaction: nop, push, or add, sub, mul and div,
// which pop the top two entries and push (second op top). Arithmetic wraps in
// two's complement and division truncates toward zero. An operation that
// cannot be done reports stack too short, division by zero or stack full and
// leaves the stack unchanged. Every input transaction produces exactly one
// output transaction carrying the status, the new top entry (zero when the
// stack is empty) and the new depth. The stack lives in a RAM; the top entry
// is also held in a register, so a binary operation needs one RAM read for
// the second entry. All arithmetic goes through one shared 33-bit adder under
// a small sequencer. Nop, push and every error finish in the idle state;
// add and sub pass through a RAM read state and a write-back state, mul
// adds a shift-and-add loop (one multiplier bit per cycle), and div adds
// sign handling for dividend and divisor, a loop of one quotient bit per
// cycle and a sign fix-up state. The worst case is therefore set by the
// division loop. A new input transaction is taken once the sequencer is
// idle and the output register is empty or being emptied in the same
// cycle. Stack contents need no clearing after reset; only entries below
// the depth are ever read.
module stack_arithmetic_unit_top #(
  parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sau_pkg::FUNC_W-1:0]    func,
  input  logic signed [sau_pkg::DATA_W-1:0] push_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sau_pkg::STATUS_W-1:0]  status,
  output logic signed [sau_pkg::DATA_W-1:0] top_value,
  output logic [sau_pkg::DEPTH_W-1:0]   depth
);

  localparam int DW    = sau_pkg::DATA_W;
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int ITW   = $clog2(DW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_NEG_A,
    S_NEG_B,
    S_DIV,
    S_FIX,
    S_WB
  } state_t;

  state_t             state;
  sau_pkg::func_t     func_r;
  logic [CNT_W-1:0]   count;
  logic [DW-1:0]      tos;
  logic [DW-1:0]      opa;
  logic [DW-1:0]      opb;
  logic [DW-1:0]      acc;
  logic [DW-1:0]      res;
  logic [ITW-1:0]     iter;
  logic               neg_a;
  logic               neg_b;

  logic               in_accept;
  logic [CNT_W-1:0]   cnt_m2;
  logic [CNT_W+6:0]   cnt_ext;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DW-1:0]      ram_wdata;
  logic [DW-1:0]      ram_rdata;

  logic [DW:0]        add_a;
  logic [DW:0]        add_b;
  logic               add_cin;
  logic [DW:0]        add_sum;

  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign cnt_m2    = count - CNT_W'(2);

  // The result fields follow the stack registers directly. They only change
  // when a new transaction completes, which cannot happen before the
  // pending result has been taken.
  assign cnt_ext   = {7'b0, count};
  assign depth     = cnt_ext[6:0];
  assign top_value = (count != '0) ? tos : '0;

  // Stack storage. Pushes write at the current count, a finished binary
  // operation writes its result over the second entry.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_m2[AW-1:0];
    ram_wdata = res;
    if (state == S_WB) begin
      ram_we = 1'b1;
    end else if (in_accept && func == sau_pkg::FUNC_PUSH
                 && count < CNT_W'(STACK_DEPTH)) begin
      ram_we    = 1'b1;
      ram_waddr = count[AW-1:0];
      ram_wdata = push_value;
    end
  end

  sau_ram #(
    .WIDTH(DW),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_m2[AW-1:0]),
    .rdata(ram_rdata)
  );

  // The one shared adder. Subtraction and negation use the inverted operand
  // with a carry in.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state)
      S_READ: begin
        add_a = {1'b0, ram_rdata};
        if (func_r == sau_pkg::FUNC_SUB) begin
          add_b   = {1'b0, ~opb};
          add_cin = 1'b1;
        end else begin
          add_b = {1'b0, opb};
        end
      end
      S_MUL: begin
        add_a = {1'b0, acc};
        add_b = {1'b0, opa};
      end
      S_NEG_A, S_FIX: begin
        add_b   = ~{1'b0, opa};
        add_cin = 1'b1;
      end
      S_NEG_B: begin
        add_b   = ~{1'b0, opb};
        add_cin = 1'b1;
      end
      S_DIV: begin
        add_a   = {acc, opa[DW-1]};
        add_b   = ~{1'b0, opb};
        add_cin = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_sum = add_a + add_b + {{DW{1'b0}}, add_cin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // A result taken in this cycle empties the output register. When a new
      // transaction is accepted in the same cycle, the idle state decides.
      if (out_valid && !out_stall && !in_accept) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            opb <= tos;
            unique case (func)
              sau_pkg::FUNC_PUSH: begin
                out_valid <= 1'b1;
                if (count >= CNT_W'(STACK_DEPTH)) begin
                  status <= sau_pkg::STATUS_FULL;
                end else begin
                  status <= sau_pkg::STATUS_OK;
                  tos    <= push_value;
                  count  <= count + CNT_W'(1);
                end
              end
              sau_pkg::FUNC_ADD, sau_pkg::FUNC_SUB,
              sau_pkg::FUNC_DIV, sau_pkg::FUNC_MUL: begin
                func_r <= sau_pkg::func_t'(func);
                if (count < CNT_W'(2)) begin
                  out_valid <= 1'b1;
                  status    <= sau_pkg::STATUS_SHORT;
                end else if (func == sau_pkg::FUNC_DIV && tos == '0) begin
                  out_valid <= 1'b1;
                  status    <= sau_pkg::STATUS_DIVZERO;
                end else begin
                  out_valid <= 1'b0;
                  state     <= S_READ;
                end
              end
              default: begin
                // Nop and the unused codes leave the stack alone.
                out_valid <= 1'b1;
                status    <= sau_pkg::STATUS_OK;
              end
            endcase
          end
        end

        S_READ: begin
          // The second entry has arrived from the RAM.
          iter <= '0;
          acc  <= '0;
          opa  <= ram_rdata;
          unique case (func_r)
            sau_pkg::FUNC_MUL: begin
              state <= S_MUL;
            end
            sau_pkg::FUNC_DIV: begin
              neg_a <= ram_rdata[DW-1];
              neg_b <= opb[DW-1];
              state <= S_NEG_A;
            end
            default: begin
              res   <= add_sum[DW-1:0];
              state <= S_WB;
            end
          endcase
        end

        S_MUL: begin
          // Shift-and-add: opa is the shifted multiplicand, opb the
          // multiplier consumed from its low end.
          if (opb[0]) begin
            acc <= add_sum[DW-1:0];
          end
          opa  <= {opa[DW-2:0], 1'b0};
          opb  <= {1'b0, opb[DW-1:1]};
          iter <= iter + ITW'(1);
          if (iter == ITW'(DW - 1)) begin
            res   <= opb[0] ? add_sum[DW-1:0] : acc;
            state <= S_WB;
          end
        end

        S_NEG_A: begin
          if (neg_a) begin
            opa <= add_sum[DW-1:0];
          end
          state <= S_NEG_B;
        end

        S_NEG_B: begin
          if (neg_b) begin
            opb <= add_sum[DW-1:0];
          end
          state <= S_DIV;
        end

        S_DIV: begin
          // Restoring division on magnitudes: acc is the partial remainder,
          // opa shifts the dividend out and the quotient in.
          if (add_sum[DW]) begin
            acc <= {acc[DW-2:0], opa[DW-1]};
          end else begin
            acc <= add_sum[DW-1:0];
          end
          opa  <= {opa[DW-2:0], ~add_sum[DW]};
          iter <= iter + ITW'(1);
          if (iter == ITW'(DW - 1)) begin
            state <= S_FIX;
          end
        end

        S_FIX: begin
          res   <= (neg_a ^ neg_b) ? add_sum[DW-1:0] : opa;
          state <= S_WB;
        end

        S_WB: begin
          tos       <= res;
          count     <= count - CNT_W'(1);
          status    <= sau_pkg::STATUS_OK;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/stack_arithmetic_unit_top_tb.sv @@
// Self-checking testbench for stack_arithmetic_unit_top: a queue-fed driver, a result
// monitor with its own stack predictor, and random idling on both channels.
// Depends on sau_pkg and the stack_arithmetic_unit_top RTL.
module stack_arithmetic_unit_top_tb;

  localparam int STACK_ENTRIES  = sau_pkg::STACK_DEPTH_D;
  localparam int RANDOM_WORK    = 850;   // push and arithmetic transactions after the directed set
  localparam int QUIET_TAIL     = 80;    // the last transactions run with no idling at all
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES   = 60;    // the longest operation is div
  localparam int MAX_REPORTS    = 10;

  // The unused operation codes must behave exactly like a nop.
  localparam logic [sau_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [sau_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

  localparam logic [sau_pkg::DATA_W-1:0] MOST_NEG = {1'b1, {(sau_pkg::DATA_W-1){1'b0}}};
  localparam logic [sau_pkg::DATA_W-1:0] MOST_POS = ~MOST_NEG;

  // One input transaction as the driver will present it.
  typedef struct packed {
    logic [sau_pkg::FUNC_W-1:0] func;
    logic [sau_pkg::DATA_W-1:0] value;
    bit                         hold;   // send only once every outstanding result has come back
  } op_item_t;

  // What the unit reports after one operation.
  typedef struct packed {
    sau_pkg::status_t            status;
    logic [sau_pkg::DATA_W-1:0]  top;
    logic [sau_pkg::DEPTH_W-1:0] depth;
  } stack_view_t;

  logic                              clk;
  logic                              rst        = 1'b1;
  logic                              in_valid   = 1'b0;
  logic                              in_stall;
  logic [sau_pkg::FUNC_W-1:0]        func       = sau_pkg::FUNC_NOP;
  logic signed [sau_pkg::DATA_W-1:0] push_value = '0;
  logic                              out_valid;
  logic                              out_stall  = 1'b0;
  logic [sau_pkg::STATUS_W-1:0]      status;
  logic signed [sau_pkg::DATA_W-1:0] top_value;
  logic [sau_pkg::DEPTH_W-1:0]       depth;

  stack_arithmetic_unit_top #(
    .STACK_DEPTH(STACK_ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .top_value (top_value),
    .depth     (depth)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stimulus waiting to be sent, and the expected reports in acceptance order.
  op_item_t    queued_ops [$];
  stack_view_t pending_results [$];

  // The predictor's own copy of the stack.
  logic [sau_pkg::DATA_W-1:0] model_entries [STACK_ENTRIES];
  int unsigned                model_count = 0;

  int unsigned planned_depth = 0;   // rough depth seen by the generator, steers the mix only
  int unsigned planned_work  = 0;
  bit          hold_next     = 1'b0;

  int unsigned ops_accepted    = 0;
  int unsigned results_checked = 0;
  int unsigned error_count     = 0;
  int unsigned idle_cycles     = 0;
  int unsigned deepest         = 0;
  int unsigned status_tally [4] = '{0, 0, 0, 0};

  logic        in_fire_q    = 1'b0;   // an input transaction was taken at the last rising edge
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned in_idle_pct  = 20;
  int unsigned out_idle_pct = 20;

  // Applies one operation to the predicted stack and returns what the unit
  // should report. Errors leave the stack as it was. Division works on
  // magnitudes so that the most negative value over -1 wraps back to itself
  // instead of overflowing in the simulator.
  function automatic stack_view_t apply_stack_op(logic [sau_pkg::FUNC_W-1:0] op,
                                                 logic [sau_pkg::DATA_W-1:0] operand);
    stack_view_t                view;
    logic [sau_pkg::DATA_W-1:0] upper;
    logic [sau_pkg::DATA_W-1:0] lower;
    logic [sau_pkg::DATA_W-1:0] num_mag;
    logic [sau_pkg::DATA_W-1:0] den_mag;
    logic [sau_pkg::DATA_W-1:0] quot;
    view.status = sau_pkg::STATUS_OK;
    case (op)
      sau_pkg::FUNC_PUSH: begin
        if (model_count >= STACK_ENTRIES) begin
          view.status = sau_pkg::STATUS_FULL;
        end else begin
          model_entries[model_count] = operand;
          model_count++;
        end
      end
      sau_pkg::FUNC_ADD, sau_pkg::FUNC_SUB, sau_pkg::FUNC_DIV, sau_pkg::FUNC_MUL: begin
        if (model_count < 2) begin
          view.status = sau_pkg::STATUS_SHORT;
        end else begin
          upper = model_entries[model_count-1];
          lower = model_entries[model_count-2];
          if (op == sau_pkg::FUNC_DIV && upper == '0) begin
            view.status = sau_pkg::STATUS_DIVZERO;
          end else begin
            case (op)
              sau_pkg::FUNC_ADD: lower = lower + upper;
              sau_pkg::FUNC_SUB: lower = lower - upper;
              sau_pkg::FUNC_MUL: lower = lower * upper;
              default: begin
                num_mag = lower[sau_pkg::DATA_W-1] ? -lower : lower;
                den_mag = upper[sau_pkg::DATA_W-1] ? -upper : upper;
                quot    = num_mag / den_mag;
                lower   = (lower[sau_pkg::DATA_W-1] ^ upper[sau_pkg::DATA_W-1]) ? -quot : quot;
              end
            endcase
            model_entries[model_count-2] = lower;
            model_count--;
          end
        end
      end
      default: ;
    endcase
    view.top   = (model_count > 0) ? model_entries[model_count-1] : '0;
    view.depth = sau_pkg::DEPTH_W'(model_count);
    return view;
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 8;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Operands lean on small values and the extremes so that division,
  // wrap-around and zero tops come up often.
  function automatic logic [sau_pkg::DATA_W-1:0] random_operand();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16) - 8;
      1: begin
        case ($urandom_range(0, 4))
          0:       return MOST_NEG;
          1:       return MOST_POS;
          2:       return '0;
          3:       return '1;
          default: return 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sau_pkg::FUNC_W-1:0] pick_binary();
    case ($urandom_range(0, 3))
      0:       return sau_pkg::FUNC_ADD;
      1:       return sau_pkg::FUNC_SUB;
      2:       return sau_pkg::FUNC_MUL;
      default: return sau_pkg::FUNC_DIV;
    endcase
  endfunction

  task automatic add_op(logic [sau_pkg::FUNC_W-1:0] op, logic [sau_pkg::DATA_W-1:0] operand);
    op_item_t item;
    item.func  = op;
    item.value = operand;
    item.hold  = hold_next;
    hold_next  = 1'b0;
    queued_ops.push_back(item);
    case (op)
      sau_pkg::FUNC_PUSH: begin
        if (planned_depth < STACK_ENTRIES) planned_depth++;
        planned_work++;
      end
      sau_pkg::FUNC_ADD, sau_pkg::FUNC_SUB, sau_pkg::FUNC_DIV, sau_pkg::FUNC_MUL: begin
        if (planned_depth >= 2) planned_depth--;
        planned_work++;
      end
      default: ;
    endcase
  endtask

  // Driver. Inputs change on the falling edge only. A new transaction is
  // loaded when the channel is empty or the previous one was just taken; a
  // stalled transaction is left untouched. Valid is decided from the queue and
  // random gaps alone, never from in_stall.
  always @(negedge clk) begin
    op_item_t next_op;
    if (!rst) begin
      if ($urandom_range(0, 127) == 0) in_idle_pct = pick_idle_pct();
      if (!in_valid || in_fire_q) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (queued_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (queued_ops[0].hold && pending_results.size() != 0) begin
          // Hold back until the unit has answered everything it was given.
          in_valid <= 1'b0;
        end else if (queued_ops.size() >= QUIET_TAIL
                     && $urandom_range(0, 99) < in_idle_pct) begin
          send_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else begin
          next_op = queued_ops.pop_front();
          in_valid   <= 1'b1;
          func       <= next_op.func;
          push_value <= next_op.value;
        end
      end
    end
  end

  // Result side back-pressure in bursts of random length, none near the end.
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 127) == 0) out_idle_pct = pick_idle_pct();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (queued_ops.size() >= QUIET_TAIL && $urandom_range(0, 99) < out_idle_pct)
          stall_left = $urandom_range(1, 17);
      end
    end
  end

  // Monitor. Everything is sampled at the rising edge. A result is checked
  // before the input taken at the same edge is predicted, since a result can
  // never belong to a transaction accepted in that same cycle.
  always @(posedge clk) begin
    stack_view_t want;
    if (rst) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid && !in_stall;

      if (out_valid && !out_stall) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("Unexpected result: status %0d top %0d depth %0d with nothing outstanding",
                     status, top_value, depth);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status || top_value !== want.top || depth !== want.depth) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display({"Result %0d mismatch: expected status %0d top %0d depth %0d,",
                        " got status %0d top %0d depth %0d"},
                       results_checked, want.status, $signed(want.top), want.depth,
                       status, top_value, depth);
          end
        end
      end

      if (in_valid && !in_stall) begin
        ops_accepted++;
        want = apply_stack_op(func, push_value);
        status_tally[want.status]++;
        if (model_count > deepest) deepest = model_count;
        pending_results.push_back(want);
      end

      // Watchdog: a healthy unit moves a transaction on one channel or the
      // other well within the limit, even across a division and long stalls.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog expired after %0d cycles without a transaction", idle_cycles);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned directed_work;
    int unsigned kind;
    int unsigned push_pct;

    // Directed part: errors on an empty and a one-entry stack, the spare
    // codes, the most negative value over -1, division by zero, add and sub
    // reaching the extremes, wrap-around of mul, and division truncating toward zero.
    add_op(sau_pkg::FUNC_ADD, '0);          // too short on an empty stack
    add_op(sau_pkg::FUNC_DIV, '0);          // too short wins over division by zero
    add_op(sau_pkg::FUNC_NOP, '1);
    add_op(FUNC_SPARE_A, '1);
    add_op(FUNC_SPARE_B, '0);
    add_op(sau_pkg::FUNC_PUSH, MOST_NEG);
    add_op(sau_pkg::FUNC_MUL, '0);          // one entry only
    add_op(sau_pkg::FUNC_PUSH, '1);
    add_op(sau_pkg::FUNC_DIV, '0);          // most negative over -1 stays most negative
    add_op(sau_pkg::FUNC_PUSH, '0);
    add_op(sau_pkg::FUNC_DIV, '0);          // division by zero, stack untouched
    add_op(sau_pkg::FUNC_ADD, '0);
    add_op(sau_pkg::FUNC_PUSH, MOST_POS);
    add_op(sau_pkg::FUNC_ADD, '0);          // gives -1
    add_op(sau_pkg::FUNC_PUSH, MOST_POS);
    add_op(sau_pkg::FUNC_SUB, '0);          // -1 minus the largest value gives the most negative value
    add_op(sau_pkg::FUNC_PUSH, 2);
    add_op(sau_pkg::FUNC_MUL, '0);          // product wraps to zero
    add_op(sau_pkg::FUNC_PUSH, -7);
    add_op(sau_pkg::FUNC_PUSH, 2);
    add_op(sau_pkg::FUNC_DIV, '0);          // -3, truncated toward zero
    add_op(sau_pkg::FUNC_PUSH, -2);
    add_op(sau_pkg::FUNC_DIV, '0);          // 1
    add_op(sau_pkg::FUNC_SUB, '0);          // 0 - 1 leaves a single entry of -1
    directed_work = planned_work;

    // The first random transaction waits until the directed set has fully drained.
    hold_next = 1'b1;

    // Random part in episodes: filling past full, draining into too-short,
    // mixed traffic steered by the expected depth, and pauses that wait for
    // every outstanding result.
    while (planned_work < directed_work + RANDOM_WORK) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        repeat ($urandom_range(64, 72)) add_op(sau_pkg::FUNC_PUSH, random_operand());
      end else if (kind < 4) begin
        repeat ($urandom_range(60, 70)) add_op(pick_binary(), random_operand());
      end else if (kind < 9) begin
        repeat ($urandom_range(20, 40)) begin
          push_pct = (planned_depth < 2) ? 80 : (planned_depth > 56) ? 30 : 50;
          kind = $urandom_range(0, 99);
          if (kind < 8) begin
            case ($urandom_range(0, 2))
              0:       add_op(sau_pkg::FUNC_NOP, $urandom);
              1:       add_op(FUNC_SPARE_A, $urandom);
              default: add_op(FUNC_SPARE_B, $urandom);
            endcase
          end else if (kind < 8 + push_pct) begin
            add_op(sau_pkg::FUNC_PUSH, random_operand());
          end else begin
            add_op(pick_binary(), random_operand());
          end
        end
      end else begin
        hold_next = 1'b1;
      end
    end

    // Reset is released on a falling edge like every other input.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the queue to empty and every predicted result to come back.
    while (queued_ops.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    // Anything arriving now would be a result nobody asked for.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display({"Checked %0d results for %0d operations: %0d ok, %0d too short,",
              " %0d divide by zero, %0d stack full"},
             results_checked, ops_accepted, status_tally[sau_pkg::STATUS_OK],
             status_tally[sau_pkg::STATUS_SHORT], status_tally[sau_pkg::STATUS_DIVZERO],
             status_tally[sau_pkg::STATUS_FULL]);
    $display("Deepest stack reached %0d of %0d entries; %0d errors found",
             deepest, STACK_ENTRIES, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/sau_pkg.sv
sv/sau_ram.sv
sv/stack_arithmetic_unit_top.sv
verif/stack_arithmetic_unit_top_tb.sv
